[rtl/bilinear_map_lookup_core_macros.svh]
// Assertion macros shared by the bilinear map lookup RTL.
`ifndef BILINEAR_MAP_LOOKUP_CORE_MACROS_SVH
`define BILINEAR_MAP_LOOKUP_CORE_MACROS_SVH

`ifndef SYNTH
`define BML_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bilinear map lookup check failed");
`define BML_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bilinear map lookup check failed");
`else
`define BML_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BML_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/bml_pkg.sv]
// Types, constants and helper functions of the bilinear map lookup.
package bml_pkg;

    localparam int MAX_COLS   = 16;
    localparam int MAX_ROWS   = 16;
    localparam int AXIS_WIDTH = 16;
    localparam int CELL_WIDTH = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 64;
    localparam int DIFF_W     = AXIS_WIDTH + 1;
    localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int OUT_W      = 24;
    localparam int FRAC_W     = 8;

    typedef logic [AXIS_WIDTH-1:0]        t_axis;
    typedef logic signed [CELL_WIDTH-1:0] t_cell;
    typedef logic signed [VAL_W-1:0]      t_val;
    typedef logic [IDX_W-1:0]             t_idx;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_COL_BP = 2'd1,
        REQ_ROW_BP = 2'd2,
        REQ_CELL   = 2'd3
    } t_req;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;

    // Index of the last breakpoint in use, count saturated into [2, max].
    function automatic t_idx last_index(input logic [CNT_W-1:0] cnt, input int max_n);
        logic [CNT_W-1:0] r;
        r = cnt;
        if (cnt < CNT_W'(2)) begin
            r = CNT_W'(2);
        end else if (32'(cnt) > max_n) begin
            r = CNT_W'(max_n);
        end
        return IDX_W'(r - CNT_W'(1));
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input t_idx row, input t_idx col);
        return CELL_AW'(32'(row) * MAX_COLS + 32'(col));
    endfunction

    // Cell value in the 8-fraction-bit working format.
    function automatic t_val cell_fixed(input t_cell c);
        return t_val'(c) <<< FRAC_W;
    endfunction

endpackage

[rtl/bml_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bml_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bml_lerp.sv]
// Serial linear interpolation: shift-add multiply then restoring divide.
module bml_lerp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bml_pkg::t_axis i_q,
    input  bml_pkg::t_axis i_q0,
    input  bml_pkg::t_axis i_q1,
    input  bml_pkg::t_val  i_v0,
    input  bml_pkg::t_val  i_v1,
    output logic          o_done,
    output bml_pkg::t_val  o_result
);
    import bml_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_ADD} t_state;

    t_state                    r_state;
    logic                      r_done;
    t_val                      r_res;
    t_val                      r_v0;
    logic                      r_neg;
    logic [VAL_W-1:0]          r_mcand;
    logic [DIFF_W-1:0]         r_mplier;
    logic [DIFF_W-1:0]         r_div;
    logic [VAL_W-1:0]          r_acc;
    logic [DIFF_W-1:0]         r_rem;
    logic [$clog2(VAL_W)-1:0]  r_cnt;

    logic signed [DIFF_W-1:0]  w_d;
    logic signed [DIFF_W-1:0]  w_b;
    t_val                      w_a;
    logic [DIFF_W:0]           w_trial;
    logic                      w_fit;

    assign w_d = $signed({1'b0, i_q1}) - $signed({1'b0, i_q0});
    assign w_b = $signed({1'b0, i_q}) - $signed({1'b0, i_q0});
    assign w_a = i_v1 - i_v0;
    assign w_trial = {r_rem, r_acc[VAL_W-1]};
    assign w_fit = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            // pulse on a zero-width interval or after the final add
            r_done <= ((r_state == ST_IDLE) && i_start && (w_d == '0))
                      || (r_state == ST_ADD);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_v0 <= i_v0;
                        if (w_d == '0) begin
                            r_res  <= i_v0;
                        end else begin
                            r_neg    <= w_a[VAL_W-1] ^ w_b[DIFF_W-1] ^ w_d[DIFF_W-1];
                            r_mcand  <= w_a[VAL_W-1] ? VAL_W'(-w_a) : VAL_W'(w_a);
                            r_mplier <= w_b[DIFF_W-1] ? DIFF_W'(-w_b) : DIFF_W'(w_b);
                            r_div    <= w_d[DIFF_W-1] ? DIFF_W'(-w_d) : DIFF_W'(w_d);
                            r_acc    <= '0;
                            r_cnt    <= '0;
                            r_state  <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (32'(r_cnt) == DIFF_W - 1) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    // quotient bits shift in behind the dividend
                    r_rem <= w_fit ? DIFF_W'(w_trial - {1'b0, r_div}) : DIFF_W'(w_trial);
                    r_acc <= {r_acc[VAL_W-2:0], w_fit};
                    r_cnt <= r_cnt + 1'b1;
                    if (32'(r_cnt) == VAL_W - 1) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_res   <= r_v0 + (r_neg ? -$signed(r_acc) : $signed(r_acc));
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

[rtl/bilinear_map_lookup_core.sv]
// Bilinear map lookup: breakpoint/cell storage, axis search and interpolation sequencer.
//
// Each input beat either loads the map (column breakpoint, row breakpoint or cell,
// chosen by tuser) or requests a lookup. A load gives no result. A lookup clamps the
// query to each axis, searches the breakpoint RAM one entry at a time (a read state,
// then a check state per entry), reads four cells from the cell RAM and runs three
// interpolations on one shared serial unit, each of 17 multiply steps and 64 divide
// steps, none for a zero-width interval. A lookup holds the input from its beat until
// its result leaves the unit, a time set mostly by the serial interpolation unit, plus
// any wait for the output register to free up. The value returned is signed with 8
// fraction bits, truncated toward zero at each stage and saturated to 24 bits. A
// finished result waits in the output register while the next beat is taken.
// Reading an entry never written gives an undefined value.
`include "bilinear_map_lookup_core_macros.svh"

module bilinear_map_lookup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] cell_col, [7:4] cell_row, [23:8] write_value, [39:24] query_x,
    // [55:40] query_y
    input  logic [55:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] interp_value, [27:24] base_col, [31:28] base_row
    output logic [31:0] m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    import bml_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLAMP0, ST_CLAMP1, ST_CLAMP2, ST_SRCH_RD, ST_SRCH_CHK,
        ST_AXIS_DONE, ST_CELL0, ST_CELL1, ST_CELL2, ST_CELL3, ST_CELL4,
        ST_LERP_LO, ST_LERP_HI, ST_LERP_V, ST_OUT
    } t_state;

    // unpack the input beat
    t_req   w_req;
    t_idx   w_col;
    t_idx   w_row;
    t_axis  w_wval;
    logic   w_accept;

    assign w_req    = t_req'(s_axis_tuser);
    assign w_col    = s_axis_tdata[3:0];
    assign w_row    = s_axis_tdata[7:4];
    assign w_wval   = s_axis_tdata[23:8];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // configuration registers
    logic [CNT_W-1:0] r_cols_in_use;
    logic [CNT_W-1:0] r_rows_in_use;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use <= CNT_W'(MAX_COLS);
            r_rows_in_use <= CNT_W'(MAX_ROWS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_COLS) begin
                r_cols_in_use <= i_cfg_data;
            end else if (i_cfg_index == CFG_ROWS) begin
                r_rows_in_use <= i_cfg_data;
            end
        end
    end

    // sequencer state
    t_state r_state;
    logic   r_axis;       // low: column axis, high: row axis
    t_axis  r_q;          // working query, clamped in place
    t_axis  r_qy;         // raw row query held during the column search
    t_axis  r_prev;       // lower bracketing breakpoint
    t_axis  r_cur;        // upper bracketing breakpoint
    t_axis  r_bplast;
    t_idx   r_idx;
    t_idx   r_last;
    t_axis  r_qx;
    t_axis  r_x0;
    t_axis  r_x1;
    t_idx   r_ix;
    t_val   r_z11;
    t_val   r_z21;
    t_val   r_z12;
    t_val   r_z22;
    t_val   r_lo;
    t_val   r_hi;
    logic   r_start;
    logic   r_mvalid;
    logic [31:0] r_mdata;

    // memories
    t_idx               w_bp_raddr;
    t_axis              w_col_rdata;
    t_axis              w_row_rdata;
    t_axis              w_bp_rdata;
    logic [CELL_AW-1:0] w_cell_raddr;
    t_cell              w_cell_rdata;
    logic               w_col_we;
    logic               w_row_we;
    logic               w_cell_we;

    assign w_col_we  = w_accept && (w_req == REQ_COL_BP) && (32'(w_col) < MAX_COLS);
    assign w_row_we  = w_accept && (w_req == REQ_ROW_BP) && (32'(w_row) < MAX_ROWS);
    assign w_cell_we = w_accept && (w_req == REQ_CELL) && (32'(w_col) < MAX_COLS)
                       && (32'(w_row) < MAX_ROWS);

    always_comb begin
        unique case (r_state)
            ST_CLAMP1:  w_bp_raddr = r_last;
            ST_SRCH_RD: w_bp_raddr = r_idx + 1'b1;
            default:    w_bp_raddr = '0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_CELL1: w_cell_raddr = cell_addr(r_idx, r_ix + 1'b1);
            ST_CELL2: w_cell_raddr = cell_addr(r_idx + 1'b1, r_ix);
            ST_CELL3: w_cell_raddr = cell_addr(r_idx + 1'b1, r_ix + 1'b1);
            default:  w_cell_raddr = cell_addr(r_idx, r_ix);
        endcase
    end

    assign w_bp_rdata = r_axis ? w_row_rdata : w_col_rdata;

    bml_ram #(.WIDTH(AXIS_WIDTH), .DEPTH(MAX_COLS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr ($clog2(MAX_COLS)'(w_col)),
        .i_wdata (w_wval),
        .i_raddr ($clog2(MAX_COLS)'(w_bp_raddr)),
        .o_rdata (w_col_rdata)
    );

    bml_ram #(.WIDTH(AXIS_WIDTH), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr ($clog2(MAX_ROWS)'(w_row)),
        .i_wdata (w_wval),
        .i_raddr ($clog2(MAX_ROWS)'(w_bp_raddr)),
        .o_rdata (w_row_rdata)
    );

    bml_ram #(.WIDTH(CELL_WIDTH), .DEPTH(CELL_DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (cell_addr(w_row, w_col)),
        .i_wdata (w_wval),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    // shared interpolation unit: column pass on both rows, then the row pass
    t_axis w_lq;
    t_axis w_lq0;
    t_axis w_lq1;
    t_val  w_lv0;
    t_val  w_lv1;
    logic  w_ldone;
    t_val  w_lres;

    always_comb begin
        w_lq  = r_qx;
        w_lq0 = r_x0;
        w_lq1 = r_x1;
        w_lv0 = r_z11;
        w_lv1 = r_z21;
        unique case (r_state)
            ST_LERP_HI: begin
                w_lv0 = r_z12;
                w_lv1 = r_z22;
            end
            ST_LERP_V: begin
                w_lq  = r_q;
                w_lq0 = r_prev;
                w_lq1 = r_cur;
                w_lv0 = r_lo;
                w_lv1 = r_hi;
            end
            default: ;
        endcase
    end

    bml_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_q      (w_lq),
        .i_q0     (w_lq0),
        .i_q1     (w_lq1),
        .i_v0     (w_lv0),
        .i_v1     (w_lv1),
        .o_done   (w_ldone),
        .o_result (w_lres)
    );

    // saturate the final value to the output range
    logic [OUT_W-1:0] w_sat;

    always_comb begin
        priority if (w_lres > t_val'(2 ** (OUT_W - 1) - 1)) begin
            w_sat = {1'b0, {(OUT_W - 1){1'b1}}};
        end else if (w_lres < -t_val'(2 ** (OUT_W - 1))) begin
            w_sat = {1'b1, {(OUT_W - 1){1'b0}}};
        end else begin
            w_sat = w_lres[OUT_W-1:0];
        end
    end

    logic [IDX_W:0] w_next2;
    assign w_next2 = {1'b0, r_idx} + (IDX_W + 1)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= 1'b0;
            r_mvalid <= 1'b0;
            r_axis   <= 1'b0;
        end else begin
            // kick the interpolation unit once the cells or the previous pass are in
            r_start <= (r_state == ST_CELL4)
                       || (((r_state == ST_LERP_LO) || (r_state == ST_LERP_HI)) && w_ldone);
            // load the output register when it is free, drop it once taken
            if ((r_state == ST_OUT) && (!r_mvalid || m_axis_tready)) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (w_req == REQ_LOOKUP)) begin
                        r_q     <= s_axis_tdata[39:24];
                        r_qy    <= s_axis_tdata[55:40];
                        r_axis  <= 1'b0;
                        r_last  <= last_index(r_cols_in_use, MAX_COLS);
                        r_state <= ST_CLAMP0;
                    end
                end
                ST_CLAMP0: r_state <= ST_CLAMP1;
                ST_CLAMP1: begin
                    // raise to the first breakpoint
                    r_prev  <= w_bp_rdata;
                    if (r_q < w_bp_rdata) begin
                        r_q <= w_bp_rdata;
                    end
                    r_state <= ST_CLAMP2;
                end
                ST_CLAMP2: begin
                    // then drop to the last breakpoint
                    r_bplast <= w_bp_rdata;
                    r_cur    <= w_bp_rdata;
                    if (r_q > w_bp_rdata) begin
                        r_q <= w_bp_rdata;
                    end
                    r_idx   <= '0;
                    r_state <= (r_last == t_idx'(1)) ? ST_AXIS_DONE : ST_SRCH_RD;
                end
                ST_SRCH_RD: r_state <= ST_SRCH_CHK;
                ST_SRCH_CHK: begin
                    if (r_q <= w_bp_rdata) begin
                        r_cur   <= w_bp_rdata;
                        r_state <= ST_AXIS_DONE;
                    end else begin
                        // advance; past the last checked entry the top interval stands
                        r_prev <= w_bp_rdata;
                        r_idx  <= r_idx + 1'b1;
                        if (w_next2 >= {1'b0, r_last}) begin
                            r_cur   <= r_bplast;
                            r_state <= ST_AXIS_DONE;
                        end else begin
                            r_state <= ST_SRCH_RD;
                        end
                    end
                end
                ST_AXIS_DONE: begin
                    if (!r_axis) begin
                        r_qx    <= r_q;
                        r_x0    <= r_prev;
                        r_x1    <= r_cur;
                        r_ix    <= r_idx;
                        r_q     <= r_qy;
                        r_axis  <= 1'b1;
                        r_last  <= last_index(r_rows_in_use, MAX_ROWS);
                        r_state <= ST_CLAMP0;
                    end else begin
                        r_state <= ST_CELL0;
                    end
                end
                ST_CELL0: r_state <= ST_CELL1;
                ST_CELL1: begin
                    r_z11   <= cell_fixed(w_cell_rdata);
                    r_state <= ST_CELL2;
                end
                ST_CELL2: begin
                    r_z21   <= cell_fixed(w_cell_rdata);
                    r_state <= ST_CELL3;
                end
                ST_CELL3: begin
                    r_z12   <= cell_fixed(w_cell_rdata);
                    r_state <= ST_CELL4;
                end
                ST_CELL4: begin
                    r_z22   <= cell_fixed(w_cell_rdata);
                    r_state <= ST_LERP_LO;
                end
                ST_LERP_LO: begin
                    if (w_ldone) begin
                        r_lo    <= w_lres;
                        r_state <= ST_LERP_HI;
                    end
                end
                ST_LERP_HI: begin
                    if (w_ldone) begin
                        r_hi    <= w_lres;
                        r_state <= ST_LERP_V;
                    end
                end
                ST_LERP_V: begin
                    if (w_ldone) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold the result in the unit until the output register is free
                    if (!r_mvalid || m_axis_tready) begin
                        r_mdata[OUT_W-1:0] <= w_sat;
                        r_mdata[27:24]     <= r_ix;
                        r_mdata[31:28]     <= r_idx;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    `BML_ASSERT_NXT(a_lookup_busy, i_clk, i_rst_n, w_accept && (w_req == REQ_LOOKUP), !s_axis_tready)
    `BML_ASSERT_IMP(a_done_in_lerp, i_clk, i_rst_n, w_ldone, (r_state == ST_LERP_LO) || (r_state == ST_LERP_HI) || (r_state == ST_LERP_V))
    `BML_ASSERT_IMP(a_search_bound, i_clk, i_rst_n, (r_state == ST_SRCH_RD) || (r_state == ST_SRCH_CHK), ({1'b0, r_idx} + 5'd1) < {1'b0, r_last})
    `BML_ASSERT_NXT(a_no_overwrite, i_clk, i_rst_n, (r_state == ST_OUT) && r_mvalid && !m_axis_tready, (r_state == ST_OUT) && r_mvalid && $stable(r_mdata))
endmodule
